>>> rtl/bfd_pkg.sv
package bfd_pkg;

    localparam int SAMPLE_BITS = 16;
    // pair and quad sums kept modulo 2^SUM_BITS, enough for bits [17:2] of a quad sum
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int NUM_CHAN    = 3;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_BITS   = $clog2(STORE_DEPTH);
    localparam int CNT_BITS    = $clog2(MAX_WIDTH);
    localparam int DIM_BITS    = 13;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIGNED_SAMPLES = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLOUR_MODE    = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef sum_t [NUM_CHAN-1:0]    sum3_t;

    typedef struct packed {
        sample_t chan_zero;
        sample_t chan_one;
        sample_t chan_two;
    } pixel_in_t;

    typedef struct packed {
        sample_t avg_zero;
        sample_t avg_one;
        sample_t avg_two;
        logic    frame_last;
    } pixel_out_t;

    // per-word role from the raster scan
    typedef struct packed {
        logic                 pair_first;
        logic                 pair_store;
        logic                 pair_emit;
        logic                 frame_last;
        logic [SLOT_BITS-1:0] slot;
    } scan_t;

    function automatic sum_t sample_ext(input sample_t raw, input logic is_signed);
        sum_t ext;
        ext = {{(SUM_BITS-SAMPLE_BITS){is_signed & raw[SAMPLE_BITS-1]}}, raw};
        return ext;
    endfunction

endpackage

>>> rtl/box_filter_decimate_2x2.sv
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       pixel_in_t  (chan_zero, chan_one, chan_two)
// out       output     out_valid / out_ready     pixel_out_t (avg_zero..avg_two, frame_last)
// cfg       input      cfg_we (no wait)          cfg_index, cfg_data
//
// one word per clock in while in_ready is high, and up to one out; the odd-row odd-column
// word reaches its output word through the registered read of the line store
// and then the output register
// reset clears counters, pair partial, pipeline valids and loads the default config
// in_ready drops only when both the quad stage and the output register hold words
// and out_ready is low; the line store needs no clearing pass
module box_filter_decimate_2x2 import bfd_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pixel_in_t               in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output pixel_out_t              out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]     cfg_data
);

    // configuration
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic                signed_reg;
    logic                colour_reg;

    logic   accept;
    logic   can_load;
    scan_t  scan;
    sum3_t  px_ext;
    sum3_t  partial_reg;
    sum3_t  pair_sum;
    sum3_t  line_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(640);
            height_reg <= DIM_BITS'(480);
            signed_reg <= 1'b0;
            colour_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                REG_SIGNED_SAMPLES: signed_reg <= cfg_data[0];
                REG_COLOUR_MODE:    colour_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign in_ready = can_load;
    assign accept   = in_valid && in_ready;

    // raster position and the role of the current word
    bfd_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .image_width  (width_reg),
        .image_height (height_reg),
        .scan         (scan)
    );

    // samples widened so sums stay exact in the low bits
    assign px_ext[0] = sample_ext(in_data.chan_zero, signed_reg);
    assign px_ext[1] = sample_ext(in_data.chan_one,  signed_reg);
    assign px_ext[2] = sample_ext(in_data.chan_two,  signed_reg);

    // horizontal pair: first pixel parked, second added on arrival
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            pair_sum[c] = partial_reg[c] + px_ext[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
        end
        else if (accept && scan.pair_first)
        begin
            partial_reg <= px_ext;
        end
    end

    // line store: written on even rows, read on odd rows; the read is always issued
    // at a later edge than the write of the same slot, so no forwarding is needed
    bfd_ram #(
        .WIDTH ($bits(sum3_t)),
        .DEPTH (STORE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (accept && scan.pair_store),
        .waddr (scan.slot),
        .wdata (pair_sum),
        .re    (accept && scan.pair_emit),
        .raddr (scan.slot),
        .rdata (line_sum)
    );

    // quad sum, shift and output register
    bfd_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && scan.pair_emit),
        .pre_sum     (pair_sum),
        .colour_mode (colour_reg),
        .frame_last  (scan.frame_last),
        .line_sum    (line_sum),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

>>> rtl/bfd_ram.sv
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bfd_scan.sv
module bfd_scan import bfd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [DIM_BITS-1:0] image_width,
    input  logic [DIM_BITS-1:0] image_height,
    output scan_t               scan
);

    logic [CNT_BITS-1:0] col_reg, col_next;
    logic [CNT_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS-1:0] ew, eh;
    logic [DIM_BITS-1:0] col_ext, row_ext;
    logic [DIM_BITS-1:0] col_lim, row_lim;
    logic                in_range;
    logic [DIM_BITS-2:0] half_w, half_h;

    // clamp dimensions to [1, max]
    always_comb
    begin
        ew = image_width;
        if (image_width > DIM_BITS'(MAX_WIDTH))
        begin
            ew = DIM_BITS'(MAX_WIDTH);
        end
        else if (image_width == '0)
        begin
            ew = DIM_BITS'(1);
        end
        eh = image_height;
        if (image_height > DIM_BITS'(MAX_HEIGHT))
        begin
            eh = DIM_BITS'(MAX_HEIGHT);
        end
        else if (image_height == '0)
        begin
            eh = DIM_BITS'(1);
        end
    end

    assign col_ext  = DIM_BITS'(col_reg);
    assign row_ext  = DIM_BITS'(row_reg);
    assign half_w   = ew[DIM_BITS-1:1];
    assign half_h   = eh[DIM_BITS-1:1];
    assign col_lim  = {half_w, 1'b0};
    assign row_lim  = {half_h, 1'b0};
    assign in_range = (col_ext < col_lim) && (row_ext < row_lim);

    always_comb
    begin
        scan.pair_first = in_range && !col_reg[0];
        scan.pair_store = in_range && col_reg[0] && !row_reg[0];
        scan.pair_emit  = in_range && col_reg[0] && row_reg[0];
        scan.slot       = col_reg[CNT_BITS-1:1];
        scan.frame_last = ((DIM_BITS-1)'(col_reg[CNT_BITS-1:1]) == half_w - 1'b1)
                       && ((DIM_BITS-1)'(row_reg[CNT_BITS-1:1]) == half_h - 1'b1);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_ext + 1'b1 >= ew)
        begin
            col_next = '0;
            if (row_ext + 1'b1 >= eh)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
        else
        begin
            col_next = col_reg + 1'b1;
            if (row_ext >= eh)
            begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/bfd_out.sv
module bfd_out import bfd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  sum3_t      pre_sum,
    input  logic       colour_mode,
    input  logic       frame_last,
    input  sum3_t      line_sum,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_out_t out_data
);

    logic       s1_valid_reg;
    sum3_t      s1_sum_reg;
    logic       s1_colour_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    pixel_out_t out_reg, out_next;
    logic       out_free;
    logic       s1_move;
    sum3_t      quad;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign can_load = !s1_valid_reg || out_free;

    // quad sum, then floor divide by four by dropping two bits; avg_one and avg_two are zero when colour mode is off
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            quad[c] = s1_sum_reg[c] + line_sum[c];
        end
        out_next.avg_zero   = quad[0][SUM_BITS-1:2];
        out_next.avg_one    = s1_colour_reg ? quad[1][SUM_BITS-1:2] : '0;
        out_next.avg_two    = s1_colour_reg ? quad[2][SUM_BITS-1:2] : '0;
        out_next.frame_last = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_sum_reg    <= pre_sum;
            s1_colour_reg <= colour_mode;
            s1_last_reg   <= frame_last;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
